[src/nrps_pkg.sv]
// Shared types, widths and codes for the nearest-range steering block.
package nrps_pkg;

    localparam int MAX_SAMPLES  = 4096;
    localparam int IDX_W        = $clog2(MAX_SAMPLES);
    localparam int CNT_W        = $clog2(MAX_SAMPLES + 1);

    localparam int RANGE_W      = 20;
    localparam int START_W      = 23;
    localparam int STEP_W       = 21;
    localparam int GAIN_W       = 16;
    localparam int CFG_DATA_W   = 23;
    localparam int CFG_IDX_W    = 3;
    localparam int CMD_W        = 32;
    localparam int TYPE_W       = 2;

    localparam int PROD1_W      = STEP_W + IDX_W + 1;
    localparam int ANGLE_W      = ((PROD1_W > START_W) ? PROD1_W : START_W) + 1;
    localparam int MUL_A_W      = (ANGLE_W > RANGE_W + 1) ? ANGLE_W : RANGE_W + 1;
    localparam int MUL_B_W      = (GAIN_W > IDX_W + 1) ? GAIN_W : IDX_W + 1;
    localparam int PROD_W       = MUL_A_W + MUL_B_W;
    localparam int GAIN_FRAC    = 8;

    localparam int IN_DATA_W    = 24;
    localparam int OUT_DATA_W   = 88;

    localparam logic [RANGE_W-1:0] SEED_MM = RANGE_W'(999000);

    localparam logic [CFG_IDX_W-1:0] CFG_VALID_MIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VALID_MAX  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TURN_GAIN  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_GAIN = 3'd5;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_STOP   = 1'b1;

    localparam logic [TYPE_W-1:0] CMD_TURN  = 2'd0;
    localparam logic [TYPE_W-1:0] CMD_DRIVE = 2'd1;
    localparam logic [TYPE_W-1:0] CMD_ZERO  = 2'd2;
    localparam logic [TYPE_W-1:0] CMD_STOP  = 2'd3;

    typedef struct packed {
        logic [RANGE_W-1:0] valid_min_mm;
        logic [RANGE_W-1:0] valid_max_mm;
        logic [START_W-1:0] start_angle_urad;
        logic [STEP_W-1:0]  step_angle_urad;
        logic [GAIN_W-1:0]  turn_gain;
        logic [GAIN_W-1:0]  drive_gain;
    } nrps_cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_IDX_MUL,
        ST_ANGLE,
        ST_GAIN_MUL,
        ST_SCALE,
        ST_DONE
    } nrps_state_t;

endpackage

[src/nrps_cfg.sv]
// Configuration register bank.
module nrps_cfg
    import nrps_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output nrps_cfg_t             cfg
);

    nrps_cfg_t cfg_reg;
    nrps_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_VALID_MIN:  cfg_next.valid_min_mm     = cfg_data[RANGE_W-1:0];
                CFG_VALID_MAX:  cfg_next.valid_max_mm     = cfg_data[RANGE_W-1:0];
                CFG_START:      cfg_next.start_angle_urad = cfg_data[START_W-1:0];
                CFG_STEP:       cfg_next.step_angle_urad  = cfg_data[STEP_W-1:0];
                CFG_TURN_GAIN:  cfg_next.turn_gain        = cfg_data[GAIN_W-1:0];
                CFG_DRIVE_GAIN: cfg_next.drive_gain       = cfg_data[GAIN_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.valid_min_mm     <= '0;
            cfg_reg.valid_max_mm     <= RANGE_W'(30000);
            cfg_reg.start_angle_urad <= START_W'(-3141593);
            cfg_reg.step_angle_urad  <= STEP_W'(1534);
            cfg_reg.turn_gain        <= GAIN_W'(256);
            cfg_reg.drive_gain       <= GAIN_W'(256);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[src/nrps_mul.sv]
// Shared signed multiplier with registered product.
module nrps_mul
    import nrps_pkg::*;
(
    input  logic                      clk,
    input  logic signed [MUL_A_W-1:0] a,
    input  logic signed [MUL_B_W-1:0] b,
    output logic signed [PROD_W-1:0]  p
);

    logic signed [PROD_W-1:0] p_reg;
    logic signed [PROD_W-1:0] p_next;

    always_comb
    begin
        p_next = PROD_W'(a) * PROD_W'(b);
    end

    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
    end

    assign p = p_reg;

endmodule

[src/nrps_ctrl.sv]
// Scan search, command sequencer and output register.
module nrps_ctrl
    import nrps_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  nrps_cfg_t                 cfg,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [IN_DATA_W-1:0]      s_tdata,
    input  logic                      s_tuser,
    input  logic                      s_tlast,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [OUT_DATA_W-1:0]     m_tdata,
    output logic [TYPE_W-1:0]         m_tuser,
    output logic signed [MUL_A_W-1:0] mul_a,
    output logic signed [MUL_B_W-1:0] mul_b,
    input  logic signed [PROD_W-1:0]  mul_p
);

    nrps_state_t state_reg, state_next;

    logic [RANGE_W-1:0]       best_range_reg, best_range_next;
    logic [IDX_W-1:0]         best_index_reg, best_index_next;
    logic [CNT_W-1:0]         sample_count_reg, sample_count_next;
    logic                     turn_next_reg, turn_next_next;
    logic                     stopped_reg, stopped_next;
    logic                     turn_sel_reg, turn_sel_next;
    logic [TYPE_W-1:0]        pend_type_reg, pend_type_next;
    logic signed [ANGLE_W-1:0] angle_reg, angle_next;

    logic                     m_valid_reg, m_valid_next;
    logic [TYPE_W-1:0]        o_type_reg, o_type_next;
    logic [CMD_W-1:0]         o_turn_reg, o_turn_next;
    logic [CMD_W-1:0]         o_drive_reg, o_drive_next;
    logic                     o_stop_reg, o_stop_next;
    logic [RANGE_W-1:0]       o_near_reg, o_near_next;

    logic                     accept;
    logic                     out_free;
    logic [RANGE_W-1:0]       in_range;
    logic                     in_req;
    logic                     hit;
    logic signed [PROD_W-1:0] p_adj;
    logic signed [PROD_W-1:0] quo;
    logic [CMD_W-1:0]         sat_val;
    logic                     ovf;

    assign in_range = s_tdata[RANGE_W-1:0];
    assign in_req   = s_tdata[RANGE_W];
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    assign hit = (in_range <= best_range_reg) && (in_range >= cfg.valid_min_mm)
              && (in_range <= cfg.valid_max_mm);

    // operand select: index product, then angle or range times gain
    always_comb
    begin
        if (state_reg == ST_IDX_MUL)
        begin
            mul_a = MUL_A_W'($signed(cfg.step_angle_urad));
            mul_b = $signed({{(MUL_B_W-IDX_W){1'b0}}, best_index_reg});
        end
        else if (turn_sel_reg)
        begin
            mul_a = MUL_A_W'(angle_reg);
            mul_b = MUL_B_W'($signed(cfg.turn_gain));
        end
        else
        begin
            mul_a = $signed({{(MUL_A_W-RANGE_W){1'b0}}, best_range_reg});
            mul_b = MUL_B_W'($signed(cfg.drive_gain));
        end
    end

    // divide by 256 toward zero, then clamp to 32 bits
    always_comb
    begin
        p_adj   = mul_p + (mul_p[PROD_W-1] ? PROD_W'((1 << GAIN_FRAC) - 1) : PROD_W'(0));
        quo     = p_adj >>> GAIN_FRAC;
        ovf     = (quo[PROD_W-1:CMD_W-1] != {(PROD_W-CMD_W+1){quo[PROD_W-1]}});
        sat_val = ovf ? {quo[PROD_W-1], {(CMD_W-1){!quo[PROD_W-1]}}} : quo[CMD_W-1:0];
    end

    always_comb
    begin
        state_next        = state_reg;
        best_range_next   = best_range_reg;
        best_index_next   = best_index_reg;
        sample_count_next = sample_count_reg;
        turn_next_next    = turn_next_reg;
        stopped_next      = stopped_reg;
        turn_sel_next     = turn_sel_reg;
        pend_type_next    = pend_type_reg;
        angle_next        = angle_reg;
        m_valid_next      = m_valid_reg && !m_tready;
        o_type_next       = o_type_reg;
        o_turn_next       = o_turn_reg;
        o_drive_next      = o_drive_reg;
        o_stop_next       = o_stop_reg;
        o_near_next       = o_near_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (s_tuser == KIND_STOP)
                    begin
                        stopped_next   = in_req;
                        pend_type_next = CMD_STOP;
                        state_next     = ST_DONE;
                    end
                    else
                    begin
                        if (sample_count_reg < CNT_W'(MAX_SAMPLES))
                        begin
                            if (hit)
                            begin
                                best_range_next = in_range;
                                best_index_next = sample_count_reg[IDX_W-1:0];
                            end
                            sample_count_next = sample_count_reg + 1'b1;
                        end
                        if (s_tlast)
                        begin
                            turn_sel_next = turn_next_reg;
                            if (stopped_reg)
                            begin
                                pend_type_next = CMD_ZERO;
                                state_next     = ST_DONE;
                            end
                            else if (turn_next_reg)
                            begin
                                state_next = ST_IDX_MUL;
                            end
                            else
                            begin
                                state_next = ST_GAIN_MUL;
                            end
                        end
                    end
                end
            end

            ST_IDX_MUL:
            begin
                state_next = ST_ANGLE;
            end

            ST_ANGLE:
            begin
                angle_next = mul_p[ANGLE_W-1:0]
                           + ANGLE_W'($signed(cfg.start_angle_urad));
                state_next = ST_GAIN_MUL;
            end

            ST_GAIN_MUL:
            begin
                state_next = ST_SCALE;
            end

            ST_SCALE:
            begin
                if (out_free)
                begin
                    m_valid_next      = 1'b1;
                    o_type_next       = turn_sel_reg ? CMD_TURN : CMD_DRIVE;
                    o_turn_next       = turn_sel_reg ? sat_val : '0;
                    o_drive_next      = turn_sel_reg ? '0 : sat_val;
                    o_stop_next       = stopped_reg;
                    o_near_next       = best_range_reg;
                    turn_next_next    = !turn_sel_reg;
                    best_range_next   = SEED_MM;
                    best_index_next   = '0;
                    sample_count_next = '0;
                    state_next        = ST_IDLE;
                end
            end

            ST_DONE:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    o_type_next  = pend_type_reg;
                    o_turn_next  = '0;
                    o_drive_next = '0;
                    o_stop_next  = stopped_reg;
                    o_near_next  = '0;
                    if (pend_type_reg == CMD_ZERO)
                    begin
                        best_range_next   = SEED_MM;
                        best_index_next   = '0;
                        sample_count_next = '0;
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            best_range_reg   <= SEED_MM;
            best_index_reg   <= '0;
            sample_count_reg <= '0;
            turn_next_reg    <= 1'b0;
            stopped_reg      <= 1'b0;
            m_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            best_range_reg   <= best_range_next;
            best_index_reg   <= best_index_next;
            sample_count_reg <= sample_count_next;
            turn_next_reg    <= turn_next_next;
            stopped_reg      <= stopped_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        turn_sel_reg  <= turn_sel_next;
        pend_type_reg <= pend_type_next;
        angle_reg     <= angle_next;
        o_type_reg    <= o_type_next;
        o_turn_reg    <= o_turn_next;
        o_drive_reg   <= o_drive_next;
        o_stop_reg    <= o_stop_next;
        o_near_reg    <= o_near_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = o_type_reg;
    assign m_tdata  = {{(OUT_DATA_W-2*CMD_W-1-RANGE_W){1'b0}},
                       o_near_reg, o_stop_reg, o_drive_reg, o_turn_reg};

endmodule

[src/nearest_range_p_steer.sv]
// Top level of the nearest-range proportional steering block.
// Range samples enter on the s_ stream, one request each; s_tlast marks the
// last sample of a scan and s_tuser set makes the request an e-stop request.
// Samples that are not last give no result. The last sample of a scan starts
// a command: a linear command goes through the gain multiply and scale states
// to its output register, an angular command first through index multiply and
// angle add (two passes through the one shared multiplier). Zero commands and
// e-stop status use the done state. s_tready is low while a command is formed.
// Commands alternate linear, angular, starting with linear after reset.
// The m_ stream carries one result per scan end or e-stop request, with its
// command type on m_tuser. When the receiver stalls, the result holds in the
// output register; samples keep being accepted, and the next command waits
// for the register to free before completing.
// Reset clears the search state, the alternation and the stop flag, and
// loads the configuration defaults. The cfg_ port writes one register per
// cycle and should be used only while the block is idle.
module nearest_range_p_steer
    import nrps_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // range_mm[19:0], stop_request[20]
    input  logic                  s_tuser,   // kind
    input  logic                  s_tlast,   // last_sample
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // turn_rate[31:0], drive_speed[63:32],
                                             // stop_state[64], nearest_mm[84:65]
    output logic [TYPE_W-1:0]     m_tuser    // command_type
);

    nrps_cfg_t                 cfg;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  mul_p;

    nrps_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    nrps_mul u_mul
    (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    nrps_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .mul_a    (mul_a),
        .mul_b    (mul_b),
        .mul_p    (mul_p)
    );

endmodule

[src/nrps_chk.sv]
// Port-level checker for the nearest-range steering block, with its bind.
module nrps_chk
    import nrps_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic                  s_tuser,
    input  logic                  s_tlast,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,
    input  logic [TYPE_W-1:0]     m_tuser
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result dropped or changed while stalled");

    a_busy_after_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == KIND_STOP || s_tlast) |=> !s_tready)
        else $error("request taken while a command is in progress");

    a_turn_only: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != CMD_TURN |-> m_tdata[CMD_W-1:0] == '0)
        else $error("turn rate set on a non-angular result");

    a_zero_stopped: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == CMD_ZERO |-> m_tdata[2*CMD_W])
        else $error("zero command without stop engaged");

endmodule

bind nearest_range_p_steer nrps_chk u_nrps_chk
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

[bench/nearest_range_p_steer_test.sv]
// Self-checking testbench for nearest_range_p_steer: directed table, then random scans.
`timescale 1ns / 100ps

module nearest_range_p_steer_test
    import nrps_pkg::*;
;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 180;
    localparam int DRAIN_CYCLES = 12;

    typedef struct packed {
        logic [TYPE_W-1:0]  ctype;
        logic [CMD_W-1:0]   turn_rate;
        logic [CMD_W-1:0]   drive_speed;
        logic               stop_state;
        logic [RANGE_W-1:0] nearest_mm;
    } command_t;

    typedef struct packed {
        bit                    is_write;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        logic                  kind;
        logic [RANGE_W-1:0]    mm;
        logic                  last;
        logic                  req;
        bit                    typed;
        command_t              want;
    } step_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [TYPE_W-1:0]     m_tuser;

    // predictor copy of the registers and search state
    logic [RANGE_W-1:0]        band_lo;
    logic [RANGE_W-1:0]        band_hi;
    logic signed [START_W-1:0] start_urad;
    logic signed [STEP_W-1:0]  step_urad;
    logic signed [GAIN_W-1:0]  turn_q8;
    logic signed [GAIN_W-1:0]  drive_q8;
    logic [RANGE_W-1:0]        best_mm;
    int                        best_idx;
    int                        seen_count;
    bit                        turn_due;
    bit                        halted;

    command_t           commands_due[$];
    step_t              plan[$];
    logic [RANGE_W-1:0] prev_mm;
    int                 mismatches;
    int                 items_sent;
    int                 cycles;
    int                 tx_quiet;
    int                 rx_quiet;
    int                 rx_gap;

    nearest_range_p_steer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("nearest_range_p_steer verification failed");
            $finish;
        end
    end

    function automatic logic [CMD_W-1:0] clamp32(input longint v);
        if (v > 64'sd2147483647)
            return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648)
            return 32'h8000_0000;
        return v[CMD_W-1:0];
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_VALID_MIN:  band_lo    = val[RANGE_W-1:0];
            CFG_VALID_MAX:  band_hi    = val[RANGE_W-1:0];
            CFG_START:      start_urad = val[START_W-1:0];
            CFG_STEP:       step_urad  = val[STEP_W-1:0];
            CFG_TURN_GAIN:  turn_q8    = val[GAIN_W-1:0];
            CFG_DRIVE_GAIN: drive_q8   = val[GAIN_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic bit predict_command(input logic k, input logic [RANGE_W-1:0] mm,
                                           input logic l, input logic q,
                                           output command_t c);
        longint angle;
        c = '0;
        if (k == KIND_STOP)
        begin
            halted       = q;
            c.ctype      = CMD_STOP;
            c.stop_state = q;
            return 1'b1;
        end
        if (seen_count < MAX_SAMPLES)
        begin
            if (mm <= best_mm && mm >= band_lo && mm <= band_hi)
            begin
                best_mm  = mm;
                best_idx = seen_count;
            end
            seen_count++;
        end
        if (!l)
            return 1'b0;
        c.stop_state = halted;
        if (halted)
            c.ctype = CMD_ZERO;
        else if (turn_due)
        begin
            angle        = longint'(start_urad) + longint'(step_urad) * longint'(best_idx);
            c.ctype      = CMD_TURN;
            c.turn_rate  = clamp32(angle * longint'(turn_q8) / 256);
            c.nearest_mm = best_mm;
            turn_due     = 1'b0;
        end
        else
        begin
            c.ctype       = CMD_DRIVE;
            c.drive_speed = clamp32(longint'(best_mm) * longint'(drive_q8) / 256);
            c.nearest_mm  = best_mm;
            turn_due      = 1'b1;
        end
        best_mm    = SEED_MM;
        best_idx   = 0;
        seen_count = 0;
        return 1'b1;
    endfunction

    function automatic void field_check(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %h got %h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    function automatic void check_command();
        command_t got;
        command_t want;
        got.ctype       = m_tuser;
        got.turn_rate   = m_tdata[31:0];
        got.drive_speed = m_tdata[63:32];
        got.stop_state  = m_tdata[64];
        got.nearest_mm  = m_tdata[84:65];
        if (commands_due.size() == 0)
        begin
            $display("%0t: unexpected command, expected none got %h", $time, got);
            mismatches++;
            return;
        end
        want = commands_due.pop_front();
        field_check("command_type", 32'(want.ctype), 32'(got.ctype));
        field_check("turn_rate", want.turn_rate, got.turn_rate);
        field_check("drive_speed", want.drive_speed, got.drive_speed);
        field_check("stop_state", 32'(want.stop_state), 32'(got.stop_state));
        field_check("nearest_mm", 32'(want.nearest_mm), 32'(got.nearest_mm));
    endfunction

    // idle length for one request; occasional runs of back-to-back traffic
    function automatic int pace(inout int quiet);
        if (quiet > 0)
        begin
            quiet--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0)
        begin
            quiet = $urandom_range(10, 60);
            return 0;
        end
        return $urandom_range(0, 14);
    endfunction

    function automatic int pick(input int lo, input int hi);
        case ($urandom_range(0, 5))
            0: return lo;
            1: return hi;
            2: return 0;
            default: return lo + int'($urandom_range(0, hi - lo));
        endcase
    endfunction

    function automatic logic [RANGE_W-1:0] draw_mm();
        logic [RANGE_W-1:0] mm;
        int lo;
        int hi;
        lo = band_lo;
        hi = (band_hi >= band_lo) ? band_hi : band_lo;
        case ($urandom_range(0, 9))
            0: mm = RANGE_W'($urandom);
            1: mm = band_lo;
            2: mm = band_hi;
            3: mm = prev_mm;
            4: mm = SEED_MM + RANGE_W'($urandom_range(0, 1));
            5: mm = (prev_mm > 50) ? prev_mm - RANGE_W'($urandom_range(0, 50)) : prev_mm;
            default: mm = RANGE_W'(lo + int'($urandom_range(0, hi - lo)));
        endcase
        prev_mm = mm;
        return mm;
    endfunction

    function automatic void row_item(input logic k, input logic [RANGE_W-1:0] mm,
                                     input logic l, input logic q);
        step_t s;
        s      = '0;
        s.kind = k;
        s.mm   = mm;
        s.last = l;
        s.req  = q;
        plan.push_back(s);
    endfunction

    function automatic void row_typed(input logic k, input logic [RANGE_W-1:0] mm,
                                      input logic l, input logic q,
                                      input logic [TYPE_W-1:0] ctype,
                                      input logic [CMD_W-1:0] turn,
                                      input logic [CMD_W-1:0] drive, input logic stop,
                                      input logic [RANGE_W-1:0] nearest);
        step_t s;
        s                  = '0;
        s.kind             = k;
        s.mm               = mm;
        s.last             = l;
        s.req              = q;
        s.typed            = 1'b1;
        s.want.ctype       = ctype;
        s.want.turn_rate   = turn;
        s.want.drive_speed = drive;
        s.want.stop_state  = stop;
        s.want.nearest_mm  = nearest;
        plan.push_back(s);
    endfunction

    function automatic void row_write(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] val);
        step_t s;
        s          = '0;
        s.is_write = 1'b1;
        s.reg_idx  = idx;
        s.reg_val  = val;
        plan.push_back(s);
    endfunction

    // starts and ends on a falling edge
    task automatic send_request(input logic k, input logic [RANGE_W-1:0] mm,
                                input logic l, input logic q,
                                input bit typed, input command_t want);
        command_t c;
        int gap;
        gap = pace(tx_quiet);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, q, mm};
        s_tuser  <= k;
        s_tlast  <= l;
        do @(posedge clk); while (!s_tready);
        if (predict_command(k, mm, l, q, c))
            commands_due.push_back(typed ? want : c);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (commands_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        apply_reg(idx, val);
        @(negedge clk);
    endtask

    task automatic load_phase(input int phase);
        int lo;
        int hi;
        int st;
        int sp;
        int tg;
        int dg;
        case (phase)
            0:
            begin
                lo = 0; hi = 1048575; st = 3141593; sp = 1000000; tg = 32767; dg = 32767;
            end
            1:
            begin
                lo = 0; hi = 1048575; st = -3141593; sp = -1000000; tg = -32768; dg = -32768;
            end
            2:
            begin
                lo = 0; hi = 30000; st = -3141593; sp = 1534; tg = 256; dg = 256;
            end
            3:
            begin
                lo = $urandom_range(500000, 1048575);
                hi = $urandom_range(0, lo - 1);
                st = pick(-3141593, 3141593); sp = pick(-1000000, 1000000);
                tg = pick(-32768, 32767); dg = pick(-32768, 32767);
            end
            default:
            begin
                lo = ($urandom_range(0, 4) == 0) ? pick(0, 1048575) : $urandom_range(0, 3000);
                hi = ($urandom_range(0, 4) == 0) ? pick(0, 1048575)
                                                 : $urandom_range(5000, 1048575);
                st = pick(-3141593, 3141593); sp = pick(-1000000, 1000000);
                tg = pick(-32768, 32767); dg = pick(-32768, 32767);
            end
        endcase
        settle();
        write_reg(CFG_VALID_MIN, CFG_DATA_W'(lo));
        write_reg(CFG_VALID_MAX, CFG_DATA_W'(hi));
        write_reg(CFG_START, CFG_DATA_W'(st));
        write_reg(CFG_STEP, CFG_DATA_W'(sp));
        write_reg(CFG_TURN_GAIN, CFG_DATA_W'(tg));
        write_reg(CFG_DRIVE_GAIN, CFG_DATA_W'(dg));
        write_reg(CFG_IDX_W'($urandom_range(6, 7)), CFG_DATA_W'($urandom));
    endtask

    task automatic send_stop_request();
        send_request(KIND_STOP, RANGE_W'($urandom), 1'($urandom_range(0, 1)),
                     $urandom_range(0, 2) == 0, 1'b0, '0);
    endtask

    task automatic send_scans(input int count);
        int stop_at;
        int len;
        stop_at = items_sent + count;
        while (items_sent < stop_at)
        begin
            if ($urandom_range(0, 9) == 0)
                send_stop_request();
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 8);
            for (int j = 0; j < len; j++)
            begin
                if ($urandom_range(0, 49) == 0)
                    send_stop_request();
                send_request(KIND_SAMPLE, draw_mm(), j == len - 1,
                             1'($urandom_range(0, 1)), 1'b0, '0);
            end
        end
    endtask

    initial
    begin : receiver
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            rx_gap = pace(rx_quiet);
            if (rx_gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (rx_gap) @(negedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            check_command();
        end
    end

    initial
    begin
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = 1'b0;
        s_tlast    = 1'b0;
        band_lo    = 0;
        band_hi    = 30000;
        start_urad = -3141593;
        step_urad  = 1534;
        turn_q8    = 256;
        drive_q8   = 256;
        best_mm    = SEED_MM;
        best_idx   = 0;
        seen_count = 0;
        turn_due   = 1'b0;
        halted     = 1'b0;
        prev_mm    = 1000;
        mismatches = 0;
        items_sent = 0;
        cycles     = 0;
        tx_quiet   = 0;
        rx_quiet   = 0;

        // reset defaults, linear first
        row_typed(KIND_SAMPLE, 5000, 1, 0, CMD_DRIVE, 0, 5000, 0, 5000);
        row_item(KIND_SAMPLE, 0, 0, 0);
        row_typed(KIND_SAMPLE, 1048575, 1, 0, CMD_TURN, 32'(-3141593), 0, 0, 0);
        row_item(KIND_SAMPLE, 30001, 0, 1);
        row_typed(KIND_SAMPLE, 30000, 1, 0, CMD_DRIVE, 0, 30000, 0, 30000);
        // nothing valid: seed range, index zero
        row_typed(KIND_SAMPLE, 40000, 1, 1, CMD_TURN, 32'(-3141593), 0, 0, SEED_MM);
        row_item(KIND_SAMPLE, 700, 0, 0);
        row_item(KIND_SAMPLE, 700, 1, 0);
        row_typed(KIND_STOP, 0, 0, 1, CMD_STOP, 0, 0, 1, 0);
        row_typed(KIND_SAMPLE, 100, 1, 0, CMD_ZERO, 0, 0, 1, 0);
        row_typed(KIND_STOP, 1048575, 1, 0, CMD_STOP, 0, 0, 0, 0);
        // tie goes to the later index
        row_item(KIND_SAMPLE, 500, 0, 0);
        row_item(KIND_SAMPLE, 300, 0, 0);
        row_item(KIND_SAMPLE, 300, 1, 0);
        // stop request in the middle of a scan
        row_item(KIND_SAMPLE, 200, 0, 0);
        row_typed(KIND_STOP, 12345, 0, 0, CMD_STOP, 0, 0, 0, 0);
        row_item(KIND_SAMPLE, 250, 1, 0);
        row_write(CFG_VALID_MIN, 999000);
        row_write(CFG_VALID_MAX, 1048575);
        row_write(CFG_START, 3141593);
        row_write(CFG_STEP, 1000000);
        row_write(CFG_TURN_GAIN, 23'h007FFF);
        row_write(CFG_DRIVE_GAIN, 23'h7F8000);
        row_write(3'd6, 23'h7FFFFF);
        row_write(3'd7, 23'h000001);
        row_item(KIND_SAMPLE, 1048575, 1, 0);
        row_typed(KIND_SAMPLE, 999000, 1, 0, CMD_DRIVE, 0, 32'(-127872000), 0, 999000);
        // inverted band
        row_write(CFG_VALID_MIN, 5000);
        row_write(CFG_VALID_MAX, 4000);
        row_item(KIND_SAMPLE, 4500, 1, 0);

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (plan[i])
        begin
            if (plan[i].is_write)
            begin
                settle();
                write_reg(plan[i].reg_idx, plan[i].reg_val);
            end
            else
                send_request(plan[i].kind, plan[i].mm, plan[i].last, plan[i].req,
                             plan[i].typed, plan[i].want);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            load_phase(p);
            send_scans(PHASE_ITEMS);
        end

        settle();
        if (mismatches == 0)
            $display("nearest_range_p_steer verification clean");
        else
            $display("nearest_range_p_steer verification failed");
        $finish;
    end

endmodule
